/* hdl/cmbf_pkg.sv */
// Shared types and constants for the cube-map bilinear footprint block.
package cmbf_pkg;

    // Fixed field widths
    localparam int UV_W     = 16;
    localparam int FACE_W   = 3;
    localparam int CFG_W    = 13;
    localparam int TAP_W    = 2;
    localparam int TEXEL_W  = 12;
    localparam int WEIGHT_W = 17;
    localparam int DIST_W   = 16;

    // Register reset and fixed-point constants
    localparam logic [CFG_W-1:0]    FS_RESET = 13'd256;
    localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'h10000;

    // Divide by three: (x * 0xAAAB) >> 17 is exact for x below 2^17
    localparam logic [15:0] RECIP3       = 16'hAAAB;
    localparam int          RECIP3_SHIFT = 17;

    // Cube faces
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    // Step directions
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Tap numbers
    localparam logic [TAP_W-1:0] TAP_LAST = 2'd3;

    typedef struct packed {
        logic [UV_W-1:0]   u;
        logic [UV_W-1:0]   v;
        logic [FACE_W-1:0] face;
    } in_word_t;

    typedef struct packed {
        logic [TAP_W-1:0]    tap;
        logic [TEXEL_W-1:0]  texel_x;
        logic [TEXEL_W-1:0]  texel_y;
        logic [FACE_W-1:0]   tap_face;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } out_word_t;

endpackage

/* hdl/cmbf_neighbour.sv */
// One texel step in a given direction, wrapping onto the adjacent cube face.
module cmbf_neighbour #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]           n,
    input  logic [COORD_BITS-1:0]           x_in,
    input  logic [COORD_BITS-1:0]           y_in,
    input  logic [cmbf_pkg::FACE_W-1:0]     face_in,
    input  logic [1:0]                      dir,
    output logic [COORD_BITS-1:0]           x_out,
    output logic [COORD_BITS-1:0]           y_out,
    output logic [cmbf_pkg::FACE_W-1:0]     face_out
);

    localparam logic [COORD_BITS-1:0] ONE  = COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] ZERO = '0;

    // Step inside the face, or apply the edge table at the border
    always_comb begin
        x_out    = x_in;
        y_out    = y_in;
        face_out = face_in;
        case (dir)
            cmbf_pkg::DIR_RIGHT: begin
                if (x_in < n) begin
                    x_out = x_in + ONE;
                end else begin
                    case (face_in)
                        cmbf_pkg::FACE_NZ: begin x_out = ZERO; face_out = cmbf_pkg::FACE_PX; end
                        cmbf_pkg::FACE_PX: begin x_out = ZERO; face_out = cmbf_pkg::FACE_PZ; end
                        cmbf_pkg::FACE_PZ: begin x_out = ZERO; face_out = cmbf_pkg::FACE_NX; end
                        cmbf_pkg::FACE_NX: begin x_out = ZERO; face_out = cmbf_pkg::FACE_NZ; end
                        cmbf_pkg::FACE_PY: begin
                            x_out = y_in; y_out = n; face_out = cmbf_pkg::FACE_NX;
                        end
                        cmbf_pkg::FACE_NY: begin
                            x_out = n - y_in; y_out = ZERO; face_out = cmbf_pkg::FACE_NX;
                        end
                        default: ;
                    endcase
                end
            end
            cmbf_pkg::DIR_LEFT: begin
                if (x_in > ZERO) begin
                    x_out = x_in - ONE;
                end else begin
                    case (face_in)
                        cmbf_pkg::FACE_NZ: begin x_out = n; face_out = cmbf_pkg::FACE_NX; end
                        cmbf_pkg::FACE_PX: begin x_out = n; face_out = cmbf_pkg::FACE_NZ; end
                        cmbf_pkg::FACE_PZ: begin x_out = n; face_out = cmbf_pkg::FACE_PX; end
                        cmbf_pkg::FACE_NX: begin x_out = n; face_out = cmbf_pkg::FACE_PZ; end
                        cmbf_pkg::FACE_PY: begin
                            x_out = n - y_in; y_out = n; face_out = cmbf_pkg::FACE_PX;
                        end
                        cmbf_pkg::FACE_NY: begin
                            x_out = y_in; y_out = ZERO; face_out = cmbf_pkg::FACE_PX;
                        end
                        default: ;
                    endcase
                end
            end
            cmbf_pkg::DIR_UP: begin
                if (y_in < n) begin
                    y_out = y_in + ONE;
                end else begin
                    case (face_in)
                        cmbf_pkg::FACE_NZ: begin
                            x_out = n - x_in; y_out = n; face_out = cmbf_pkg::FACE_PY;
                        end
                        cmbf_pkg::FACE_NX: begin
                            x_out = n; y_out = x_in; face_out = cmbf_pkg::FACE_PY;
                        end
                        cmbf_pkg::FACE_PZ: begin
                            y_out = ZERO; face_out = cmbf_pkg::FACE_PY;
                        end
                        cmbf_pkg::FACE_PX: begin
                            x_out = ZERO; y_out = n - x_in; face_out = cmbf_pkg::FACE_PY;
                        end
                        cmbf_pkg::FACE_PY: begin
                            x_out = n - x_in; y_out = n; face_out = cmbf_pkg::FACE_NZ;
                        end
                        cmbf_pkg::FACE_NY: begin
                            y_out = ZERO; face_out = cmbf_pkg::FACE_PZ;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                if (y_in > ZERO) begin
                    y_out = y_in - ONE;
                end else begin
                    case (face_in)
                        cmbf_pkg::FACE_NZ: begin
                            x_out = n - x_in; y_out = ZERO; face_out = cmbf_pkg::FACE_NY;
                        end
                        cmbf_pkg::FACE_NX: begin
                            x_out = n; y_out = n - x_in; face_out = cmbf_pkg::FACE_NY;
                        end
                        cmbf_pkg::FACE_PZ: begin
                            y_out = n; face_out = cmbf_pkg::FACE_NY;
                        end
                        cmbf_pkg::FACE_PX: begin
                            x_out = ZERO; y_out = x_in; face_out = cmbf_pkg::FACE_NY;
                        end
                        cmbf_pkg::FACE_PY: begin
                            y_out = n; face_out = cmbf_pkg::FACE_PZ;
                        end
                        cmbf_pkg::FACE_NY: begin
                            x_out = n - x_in; y_out = ZERO; face_out = cmbf_pkg::FACE_NZ;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    end

endmodule

/* hdl/cube_map_bilinear_footprint.sv */
// The first tap of a word leaves after it has passed three pipeline stages and the tap
// register; the other three taps follow one a cycle while m_ready is high.
// The input rate is set by the result channel moving one tap per cycle while m_ready
// is high; the pipeline itself takes a word every cycle while the tap register can load.
// Reset: synchronous, active low; empties the pipeline and sets the face size to 256.
module cube_map_bilinear_footprint #(
    parameter int COORD_BITS   = 12,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cmbf_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cmbf_pkg::out_word_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cmbf_pkg::CFG_W-1:0]    cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int UVF   = UV_FRAC_BITS;
    localparam int FSW   = CB + 1;
    localparam int CMPW  = (FSW > cmbf_pkg::CFG_W) ? FSW : cmbf_pkg::CFG_W;
    localparam int UB    = (UVF < cmbf_pkg::UV_W) ? UVF : cmbf_pkg::UV_W;
    localparam int PW    = UVF + FSW;
    localparam int DSW   = UVF + cmbf_pkg::DIST_W;
    localparam int DSH   = (UVF >= 16) ? (UVF - 16) : (16 - UVF);
    localparam int WW    = cmbf_pkg::WEIGHT_W;
    localparam int TPW   = WW + 16;

    localparam logic [CMPW-1:0] LIMIT = CMPW'(1) << CB;
    localparam logic [UVF-1:0]  HALF  = UVF'(1) << (UVF - 1);

    // Clamp a raw face size to the range 1 .. 2^COORD_BITS
    function automatic logic [FSW-1:0] clamp_fs(input logic [cmbf_pkg::CFG_W-1:0] raw);
        logic [CMPW-1:0] r;
        r = CMPW'(raw);
        if (r == '0) begin
            r = CMPW'(1);
        end else if (r > LIMIT) begin
            r = LIMIT;
        end
        return FSW'(r);
    endfunction

    // ---------------- configuration ----------------
    logic [FSW-1:0] fs_reg, fs_next;
    logic [CB-1:0]  n_reg, n_next;

    assign cfg_ready = 1'b1;
    assign fs_next   = clamp_fs(cfg_data);
    assign n_next    = CB'(fs_next - FSW'(1));

    // Store the clamped size and the last texel index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg <= clamp_fs(cmbf_pkg::FS_RESET);
            n_reg  <= CB'(clamp_fs(cmbf_pkg::FS_RESET) - FSW'(1));
        end else if (cfg_valid && cfg_ready) begin
            fs_reg <= fs_next;
            n_reg  <= n_next;
        end
    end

    // ---------------- flow control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, out_load;
    logic [cmbf_pkg::TAP_W-1:0] cnt_reg;

    assign out_load = !out_valid_reg || (m_ready && cnt_reg == cmbf_pkg::TAP_LAST);
    assign rdy3     = !s3_valid_reg || out_load;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_ready  = rdy1;

    // ---------------- stage 1: scale by face size ----------------
    logic [PW-1:0]                 s1_p_reg [2];
    logic [PW-1:0]                 s1_p_next [2];
    logic [cmbf_pkg::FACE_W-1:0]   s1_face_reg;

    assign s1_p_next[0] = PW'(s_data.u[UB-1:0]) * PW'(fs_reg);
    assign s1_p_next[1] = PW'(s_data.v[UB-1:0]) * PW'(fs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (rdy1) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) begin
            s1_p_reg[0] <= s1_p_next[0];
            s1_p_reg[1] <= s1_p_next[1];
            s1_face_reg <= s_data.face;
        end
    end

    // ---------------- stage 2: split into texel, distance and direction ----------------
    logic [CB-1:0]                 s2_idx_reg [2], s2_idx_next [2];
    logic [cmbf_pkg::DIST_W-1:0]   s2_d_reg [2], s2_d_next [2];
    logic                          s2_wrap_reg [2], s2_wrap_next [2];
    logic [1:0]                    s2_dir_reg [2], s2_dir_next [2];
    logic [cmbf_pkg::FACE_W-1:0]   s2_face_reg;
    logic [UVF-1:0]                frac [2];
    logic [UVF-1:0]                ctr_ofs [2];
    logic [DSW-1:0]                ctr_ofs_w [2];
    logic                          below [2], above [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            frac[a]          = s1_p_reg[a][UVF-1:0];
            s2_idx_next[a]   = CB'(s1_p_reg[a] >> UVF);
            below[a]         = frac[a] < HALF;
            above[a]         = frac[a] > HALF;
            if (below[a]) begin
                ctr_ofs[a] = HALF - frac[a];
            end else if (above[a]) begin
                ctr_ofs[a] = frac[a] - HALF;
            end else begin
                ctr_ofs[a] = '0;
            end
            ctr_ofs_w[a] = DSW'(ctr_ofs[a]);
            if (UVF >= 16) begin
                s2_d_next[a] = cmbf_pkg::DIST_W'(ctr_ofs_w[a] >> DSH);
            end else begin
                s2_d_next[a] = cmbf_pkg::DIST_W'(ctr_ofs_w[a] << DSH);
            end
            s2_wrap_next[a] = (below[a] && s2_idx_next[a] == '0) ||
                              (above[a] && s2_idx_next[a] >= n_reg);
        end
        s2_dir_next[0] = below[0] ? cmbf_pkg::DIR_LEFT : cmbf_pkg::DIR_RIGHT;
        s2_dir_next[1] = below[1] ? cmbf_pkg::DIR_DOWN : cmbf_pkg::DIR_UP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && rdy2) begin
            for (int a = 0; a < 2; a++) begin
                s2_idx_reg[a]  <= s2_idx_next[a];
                s2_d_reg[a]    <= s2_d_next[a];
                s2_wrap_reg[a] <= s2_wrap_next[a];
                s2_dir_reg[a]  <= s2_dir_next[a];
            end
            s2_face_reg <= s1_face_reg;
        end
    end

    // ---------------- stage 3: weights and the u and v edge neighbours ----------------
    logic [WW-1:0]                 near [2], far [2];
    logic [2*WW-1:0]               prod [4];
    logic [WW-1:0]                 s3_w_reg [4], s3_w_next [4];
    logic [CB-1:0]                 s3_x_reg [3], s3_x_next [3];
    logic [CB-1:0]                 s3_y_reg [3], s3_y_next [3];
    logic [cmbf_pkg::FACE_W-1:0]   s3_f_reg [3], s3_f_next [3];
    logic                          s3_wrap_reg [2];
    logic [1:0]                    s3_dir_reg [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            far[a]  = WW'(s2_d_reg[a]);
            near[a] = cmbf_pkg::ONE_Q16 - far[a];
        end
        prod[0] = (2*WW)'(near[0]) * (2*WW)'(near[1]);
        prod[1] = (2*WW)'(far[0])  * (2*WW)'(near[1]);
        prod[2] = (2*WW)'(near[0]) * (2*WW)'(far[1]);
        prod[3] = (2*WW)'(far[0])  * (2*WW)'(far[1]);
        for (int k = 0; k < 4; k++) begin
            s3_w_next[k] = prod[k][WW+15:16];
        end
    end

    assign s3_x_next[0] = s2_idx_reg[0];
    assign s3_y_next[0] = s2_idx_reg[1];
    assign s3_f_next[0] = s2_face_reg;

    cmbf_neighbour #(.COORD_BITS(CB)) u_nb_u (
        .n        (n_reg),
        .x_in     (s2_idx_reg[0]),
        .y_in     (s2_idx_reg[1]),
        .face_in  (s2_face_reg),
        .dir      (s2_dir_reg[0]),
        .x_out    (s3_x_next[1]),
        .y_out    (s3_y_next[1]),
        .face_out (s3_f_next[1])
    );

    cmbf_neighbour #(.COORD_BITS(CB)) u_nb_v (
        .n        (n_reg),
        .x_in     (s2_idx_reg[0]),
        .y_in     (s2_idx_reg[1]),
        .face_in  (s2_face_reg),
        .dir      (s2_dir_reg[1]),
        .x_out    (s3_x_next[2]),
        .y_out    (s3_y_next[2]),
        .face_out (s3_f_next[2])
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (rdy3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && rdy3) begin
            for (int k = 0; k < 4; k++) begin
                s3_w_reg[k] <= s3_w_next[k];
            end
            for (int k = 0; k < 3; k++) begin
                s3_x_reg[k] <= s3_x_next[k];
                s3_y_reg[k] <= s3_y_next[k];
                s3_f_reg[k] <= s3_f_next[k];
            end
            s3_wrap_reg[0] <= s2_wrap_reg[0];
            s3_wrap_reg[1] <= s2_wrap_reg[1];
            s3_dir_reg[0]  <= s2_dir_reg[0];
            s3_dir_reg[1]  <= s2_dir_reg[1];
        end
    end

    // ---------------- stage 4: diagonal tap, corner fix-up, tap register ----------------
    logic                          corner, u_first_v;
    logic [CB-1:0]                 d_x_in, d_y_in, d_x, d_y;
    logic [cmbf_pkg::FACE_W-1:0]   d_f_in, d_f;
    logic [1:0]                    d_dir;
    logic [TPW-1:0]                third_prod;
    logic [WW-1:0]                 third;
    logic [CB-1:0]                 tx [4], ty [4];
    logic [cmbf_pkg::FACE_W-1:0]   tf [4];
    logic [WW-1:0]                 tw [4];
    cmbf_pkg::out_word_t           out_taps_reg [4], out_taps_next [4];

    assign corner    = s3_wrap_reg[0] && s3_wrap_reg[1];
    assign u_first_v = s3_wrap_reg[0] && !s3_wrap_reg[1];

    // Walk along v first when only u crosses an edge
    assign d_x_in = u_first_v ? s3_x_reg[2] : s3_x_reg[1];
    assign d_y_in = u_first_v ? s3_y_reg[2] : s3_y_reg[1];
    assign d_f_in = u_first_v ? s3_f_reg[2] : s3_f_reg[1];
    assign d_dir  = u_first_v ? s3_dir_reg[0] : s3_dir_reg[1];

    cmbf_neighbour #(.COORD_BITS(CB)) u_nb_diag (
        .n        (n_reg),
        .x_in     (d_x_in),
        .y_in     (d_y_in),
        .face_in  (d_f_in),
        .dir      (d_dir),
        .x_out    (d_x),
        .y_out    (d_y),
        .face_out (d_f)
    );

    assign third_prod = TPW'(s3_w_reg[3]) * TPW'(cmbf_pkg::RECIP3);
    assign third      = WW'(third_prod >> cmbf_pkg::RECIP3_SHIFT);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tx[k] = s3_x_reg[k];
            ty[k] = s3_y_reg[k];
            tf[k] = s3_f_reg[k];
            tw[k] = corner ? (s3_w_reg[k] + third) : s3_w_reg[k];
        end
        // At a corner the diagonal repeats the primary texel with no weight
        tx[3] = corner ? s3_x_reg[0] : d_x;
        ty[3] = corner ? s3_y_reg[0] : d_y;
        tf[3] = corner ? s3_f_reg[0] : d_f;
        tw[3] = corner ? '0 : s3_w_reg[3];
        for (int k = 0; k < 4; k++) begin
            out_taps_next[k].tap      = cmbf_pkg::TAP_W'(k);
            out_taps_next[k].texel_x  = cmbf_pkg::TEXEL_W'(tx[k]);
            out_taps_next[k].texel_y  = cmbf_pkg::TEXEL_W'(ty[k]);
            out_taps_next[k].tap_face = tf[k];
            out_taps_next[k].weight   = tw[k];
            out_taps_next[k].last     = (k == 3);
        end
    end

    // Hold four taps, advance one per accepted result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (out_load) begin
            out_valid_reg <= s3_valid_reg;
            cnt_reg       <= '0;
        end else if (m_ready) begin
            cnt_reg       <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg && out_load) begin
            for (int k = 0; k < 4; k++) begin
                out_taps_reg[k] <= out_taps_next[k];
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_taps_reg[cnt_reg];

endmodule

/* sim/cube_map_bilinear_footprint_tb.sv */
// Self-checking testbench for the cube-map bilinear footprint block.
`timescale 1ns / 1ps

module cube_map_bilinear_footprint_tb;

    localparam logic [cmbf_pkg::CFG_W-1:0]  TEXEL_LIMIT       = 13'd4096;
    localparam logic [cmbf_pkg::FACE_W-1:0] FACE_NONE6        = 3'd6;
    localparam logic [cmbf_pkg::FACE_W-1:0] FACE_NONE7        = 3'd7;
    localparam int                          DRAIN_CYCLES      = 8;
    localparam int                          LONG_STALL_CYCLES = 300;
    localparam int                          CYCLE_LIMIT       = 300000;
    localparam int                          ITEMS_PER_PHASE   = 21;
    localparam int                          PHASE_COUNT       = 9;

    typedef enum logic [1:0] {SIDE_MID, SIDE_LOW, SIDE_HIGH} side_t;

    typedef struct packed {
        logic [cmbf_pkg::TEXEL_W-1:0] x;
        logic [cmbf_pkg::TEXEL_W-1:0] y;
        logic [cmbf_pkg::FACE_W-1:0]  f;
    } cube_texel_t;

    typedef cmbf_pkg::out_word_t [3:0] tap_quad_t;

    typedef struct packed {
        logic [cmbf_pkg::CFG_W-1:0]    fs;
        logic [cmbf_pkg::UV_W-1:0]     u;
        logic [cmbf_pkg::UV_W-1:0]     v;
        logic [cmbf_pkg::FACE_W-1:0]   face;
        logic                          typed;
        logic [cmbf_pkg::WEIGHT_W-1:0] w0;
    } vector_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    cmbf_pkg::in_word_t         s_data;
    logic                       m_valid;
    logic                       m_ready;
    cmbf_pkg::out_word_t        m_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [cmbf_pkg::CFG_W-1:0] cfg_data;

    cmbf_pkg::out_word_t        expected_taps[$];
    cmbf_pkg::out_word_t        tap_want;
    logic [cmbf_pkg::CFG_W-1:0] fs_reg;
    int                         error_count = 0;
    int                         taps_seen = 0;
    int                         cycle_count = 0;
    bit                         quiet_tail = 1'b0;
    bit                         long_stall_req = 1'b0;
    bit                         long_stall_on = 1'b0;

    // Directed words; w0 holds the tap 0 weight where it is obvious by hand
    vector_row_t directed_rows[25] = '{
        // reset size: centred, corners, edges, exact centre on an edge, bad faces
        '{13'd256,  16'h0080, 16'h0080, cmbf_pkg::FACE_PX, 1'b1, cmbf_pkg::ONE_Q16},
        '{13'd256,  16'h0000, 16'h0000, cmbf_pkg::FACE_PX, 1'b1, 17'd21845},
        '{13'd256,  16'hFFFF, 16'hFFFF, cmbf_pkg::FACE_NX, 1'b0, 17'd0},
        '{13'd256,  16'h0000, 16'h8000, cmbf_pkg::FACE_PY, 1'b0, 17'd0},
        '{13'd256,  16'hFFFF, 16'h4000, cmbf_pkg::FACE_NY, 1'b0, 17'd0},
        '{13'd256,  16'h0040, 16'hFFC0, cmbf_pkg::FACE_PZ, 1'b0, 17'd0},
        '{13'd256,  16'hFFC0, 16'h0040, cmbf_pkg::FACE_NZ, 1'b0, 17'd0},
        '{13'd256,  16'h0080, 16'h0040, cmbf_pkg::FACE_PX, 1'b0, 17'd0},
        '{13'd256,  16'hFF80, 16'h1234, cmbf_pkg::FACE_NZ, 1'b0, 17'd0},
        '{13'd256,  16'h0000, 16'h0080, FACE_NONE6,        1'b0, 17'd0},
        '{13'd256,  16'hFFFF, 16'hFFFF, FACE_NONE7,        1'b0, 17'd0},
        '{13'd256,  16'h1234, 16'h5678, cmbf_pkg::FACE_NY, 1'b0, 17'd0},
        // one texel per face
        '{13'd1,    16'h8000, 16'h8000, cmbf_pkg::FACE_PX, 1'b1, cmbf_pkg::ONE_Q16},
        '{13'd1,    16'h0000, 16'h0000, cmbf_pkg::FACE_NY, 1'b1, 17'd21845},
        '{13'd1,    16'hFFFF, 16'h7FFF, cmbf_pkg::FACE_PY, 1'b0, 17'd0},
        // zero size acts as one texel
        '{13'd0,    16'h8000, 16'h8000, cmbf_pkg::FACE_NX, 1'b1, cmbf_pkg::ONE_Q16},
        '{13'd0,    16'hC000, 16'h3000, cmbf_pkg::FACE_PZ, 1'b0, 17'd0},
        // largest face
        '{13'd4096, 16'h0008, 16'h0008, cmbf_pkg::FACE_PX, 1'b1, cmbf_pkg::ONE_Q16},
        '{13'd4096, 16'h0000, 16'hFFFF, cmbf_pkg::FACE_NZ, 1'b0, 17'd0},
        '{13'd4096, 16'hFFF8, 16'hFFF8, cmbf_pkg::FACE_NY, 1'b1, cmbf_pkg::ONE_Q16},
        // oversize saturates to the largest face
        '{13'd8191, 16'h0008, 16'h0008, cmbf_pkg::FACE_NX, 1'b1, cmbf_pkg::ONE_Q16},
        '{13'd8191, 16'hFFFF, 16'h0000, cmbf_pkg::FACE_PY, 1'b0, 17'd0},
        '{13'd4097, 16'hFFFF, 16'hFFFF, cmbf_pkg::FACE_PZ, 1'b0, 17'd0},
        // odd size
        '{13'd3,    16'h5555, 16'hAAAA, cmbf_pkg::FACE_PY, 1'b0, 17'd0},
        '{13'd3,    16'hFFFF, 16'h0001, cmbf_pkg::FACE_NX, 1'b0, 17'd0}
    };

    logic [cmbf_pkg::CFG_W-1:0] phase_sizes[PHASE_COUNT] = '{
        13'd256, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd2, 13'd3, 13'd100, 13'd4095
    };

    cube_map_bilinear_footprint u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Clamp the register to the usable face sizes
    function automatic logic [cmbf_pkg::CFG_W-1:0] effective_size(
        input logic [cmbf_pkg::CFG_W-1:0] fs);
        if (fs == '0) begin
            return 13'd1;
        end
        return (fs > TEXEL_LIMIT) ? TEXEL_LIMIT : fs;
    endfunction

    function automatic cube_texel_t at_texel(input logic [cmbf_pkg::TEXEL_W-1:0] x,
                                             input logic [cmbf_pkg::TEXEL_W-1:0] y,
                                             input logic [cmbf_pkg::FACE_W-1:0] f);
        cube_texel_t t;
        t.x = x;
        t.y = y;
        t.f = f;
        return t;
    endfunction

    // Step one texel; past an edge, land on the adjacent face
    function automatic cube_texel_t step_texel(input cube_texel_t c, input logic [1:0] dir,
                                               input logic [cmbf_pkg::TEXEL_W-1:0] n);
        cube_texel_t r;
        r = c;
        case (dir)
            cmbf_pkg::DIR_RIGHT: begin
                if (c.x < n) begin
                    r.x = c.x + 12'd1;
                end else begin
                    case (c.f)
                        cmbf_pkg::FACE_NZ: r = at_texel(12'd0, c.y, cmbf_pkg::FACE_PX);
                        cmbf_pkg::FACE_PX: r = at_texel(12'd0, c.y, cmbf_pkg::FACE_PZ);
                        cmbf_pkg::FACE_PZ: r = at_texel(12'd0, c.y, cmbf_pkg::FACE_NX);
                        cmbf_pkg::FACE_NX: r = at_texel(12'd0, c.y, cmbf_pkg::FACE_NZ);
                        cmbf_pkg::FACE_PY: r = at_texel(c.y, n, cmbf_pkg::FACE_NX);
                        cmbf_pkg::FACE_NY: r = at_texel(n - c.y, 12'd0, cmbf_pkg::FACE_NX);
                        default: r = c;
                    endcase
                end
            end
            cmbf_pkg::DIR_LEFT: begin
                if (c.x > 0) begin
                    r.x = c.x - 12'd1;
                end else begin
                    case (c.f)
                        cmbf_pkg::FACE_NZ: r = at_texel(n, c.y, cmbf_pkg::FACE_NX);
                        cmbf_pkg::FACE_PX: r = at_texel(n, c.y, cmbf_pkg::FACE_NZ);
                        cmbf_pkg::FACE_PZ: r = at_texel(n, c.y, cmbf_pkg::FACE_PX);
                        cmbf_pkg::FACE_NX: r = at_texel(n, c.y, cmbf_pkg::FACE_PZ);
                        cmbf_pkg::FACE_PY: r = at_texel(n - c.y, n, cmbf_pkg::FACE_PX);
                        cmbf_pkg::FACE_NY: r = at_texel(c.y, 12'd0, cmbf_pkg::FACE_PX);
                        default: r = c;
                    endcase
                end
            end
            cmbf_pkg::DIR_UP: begin
                if (c.y < n) begin
                    r.y = c.y + 12'd1;
                end else begin
                    case (c.f)
                        cmbf_pkg::FACE_NZ: r = at_texel(n - c.x, n, cmbf_pkg::FACE_PY);
                        cmbf_pkg::FACE_NX: r = at_texel(n, c.x, cmbf_pkg::FACE_PY);
                        cmbf_pkg::FACE_PZ: r = at_texel(c.x, 12'd0, cmbf_pkg::FACE_PY);
                        cmbf_pkg::FACE_PX: r = at_texel(12'd0, n - c.x, cmbf_pkg::FACE_PY);
                        cmbf_pkg::FACE_PY: r = at_texel(n - c.x, n, cmbf_pkg::FACE_NZ);
                        cmbf_pkg::FACE_NY: r = at_texel(c.x, 12'd0, cmbf_pkg::FACE_PZ);
                        default: r = c;
                    endcase
                end
            end
            default: begin
                if (c.y > 0) begin
                    r.y = c.y - 12'd1;
                end else begin
                    case (c.f)
                        cmbf_pkg::FACE_NZ: r = at_texel(n - c.x, 12'd0, cmbf_pkg::FACE_NY);
                        cmbf_pkg::FACE_NX: r = at_texel(n, n - c.x, cmbf_pkg::FACE_NY);
                        cmbf_pkg::FACE_PZ: r = at_texel(c.x, n, cmbf_pkg::FACE_NY);
                        cmbf_pkg::FACE_PX: r = at_texel(12'd0, c.x, cmbf_pkg::FACE_NY);
                        cmbf_pkg::FACE_PY: r = at_texel(c.x, n, cmbf_pkg::FACE_PZ);
                        cmbf_pkg::FACE_NY: r = at_texel(n - c.x, 12'd0, cmbf_pkg::FACE_NZ);
                        default: r = c;
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    // Scale one coordinate: texel index, distance from the texel centre, side
    function automatic void split_coord(input logic [cmbf_pkg::UV_W-1:0] c,
                                        input logic [cmbf_pkg::CFG_W-1:0] fs,
                                        output logic [cmbf_pkg::TEXEL_W-1:0] idx,
                                        output logic [cmbf_pkg::WEIGHT_W-1:0] ctr_dist,
                                        output side_t side);
        logic [28:0] p;
        logic [15:0] f;
        p = c * fs;
        idx = p[27:16];
        f = p[15:0];
        if (f < 16'h8000) begin
            ctr_dist = 17'h8000 - f;
            side = SIDE_LOW;
        end else if (f > 16'h8000) begin
            ctr_dist = f - 17'h8000;
            side = SIDE_HIGH;
        end else begin
            ctr_dist = '0;
            side = SIDE_MID;
        end
    endfunction

    function automatic logic [cmbf_pkg::WEIGHT_W-1:0] q16_mul(
        input logic [cmbf_pkg::WEIGHT_W-1:0] a,
        input logic [cmbf_pkg::WEIGHT_W-1:0] b);
        logic [33:0] prod;
        prod = {17'd0, a} * {17'd0, b};
        return prod[32:16];
    endfunction

    // Work out the four taps that one sample word should produce
    function automatic tap_quad_t predict_taps(input cmbf_pkg::in_word_t word,
                                               input logic [cmbf_pkg::CFG_W-1:0] cfg);
        tap_quad_t                               q;
        logic [cmbf_pkg::CFG_W-1:0]              fs;
        logic [cmbf_pkg::TEXEL_W-1:0]            n, px, py;
        logic [cmbf_pkg::WEIGHT_W-1:0]           ax, ay, third;
        logic [3:0][cmbf_pkg::WEIGHT_W-1:0]      w;
        side_t                                   sx, sy;
        logic [1:0]                              dir_u, dir_v;
        logic                                    wrap_u, wrap_v;
        cube_texel_t [3:0]                       t;
        fs = effective_size(cfg);
        n = 12'(fs - 13'd1);
        split_coord(word.u, fs, px, ax, sx);
        split_coord(word.v, fs, py, ay, sy);

        w[0] = q16_mul(cmbf_pkg::ONE_Q16 - ax, cmbf_pkg::ONE_Q16 - ay);
        w[1] = q16_mul(ax, cmbf_pkg::ONE_Q16 - ay);
        w[2] = q16_mul(cmbf_pkg::ONE_Q16 - ax, ay);
        w[3] = q16_mul(ax, ay);

        dir_u = (sx == SIDE_LOW) ? cmbf_pkg::DIR_LEFT : cmbf_pkg::DIR_RIGHT;
        dir_v = (sy == SIDE_LOW) ? cmbf_pkg::DIR_DOWN : cmbf_pkg::DIR_UP;
        wrap_u = (sx == SIDE_LOW && px == '0) || (sx == SIDE_HIGH && px >= n);
        wrap_v = (sy == SIDE_LOW && py == '0) || (sy == SIDE_HIGH && py >= n);

        t[0] = at_texel(px, py, word.face);
        if (wrap_u && wrap_v) begin
            // corner: no diagonal, give a third of its weight to each of the rest
            third = w[3] / 3;
            t[1] = step_texel(t[0], dir_u, n);
            t[2] = step_texel(t[0], dir_v, n);
            t[3] = t[0];
            w[0] = w[0] + third;
            w[1] = w[1] + third;
            w[2] = w[2] + third;
            w[3] = '0;
        end else if (wrap_u) begin
            t[1] = step_texel(t[0], dir_u, n);
            t[2] = step_texel(t[0], dir_v, n);
            t[3] = step_texel(t[2], dir_u, n);
        end else begin
            t[1] = step_texel(t[0], dir_u, n);
            t[2] = step_texel(t[0], dir_v, n);
            t[3] = step_texel(t[1], dir_v, n);
        end

        for (int k = 0; k < 4; k++) begin
            q[k].tap      = 2'(k);
            q[k].texel_x  = t[k].x;
            q[k].texel_y  = t[k].y;
            q[k].tap_face = t[k].f;
            q[k].weight   = w[k];
            q[k].last     = (2'(k) == cmbf_pkg::TAP_LAST);
        end
        return q;
    endfunction

    // Bias coordinates toward edge texels and exact centres
    function automatic logic [cmbf_pkg::UV_W-1:0] pick_coord(
        input logic [cmbf_pkg::CFG_W-1:0] fs);
        logic [cmbf_pkg::TEXEL_W-1:0] n, idx;
        logic [15:0]                  frac;
        logic [31:0]                  target, u;
        n = 12'(fs - 13'd1);
        if ($urandom_range(0, 9) < 3) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0: idx = '0;
            1: idx = n;
            2: idx = (n != '0) ? n - 12'd1 : '0;
            default: idx = 12'($urandom_range(0, n));
        endcase
        case ($urandom_range(0, 3))
            0: frac = 16'h8000;
            1: frac = 16'($urandom);
            2: frac = 16'($urandom_range(0, 255));
            default: frac = 16'hFFFF - 16'($urandom_range(0, 255));
        endcase
        target = {4'd0, idx, frac};
        u = (target + fs - 1) / fs;
        return (u > 32'hFFFF) ? 16'hFFFF : u[15:0];
    endfunction

    function automatic logic [cmbf_pkg::FACE_W-1:0] pick_face();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return FACE_NONE6;
        end else if (r == 1) begin
            return FACE_NONE7;
        end
        return 3'(r % 6);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [cmbf_pkg::WEIGHT_W-1:0] got,
                               input logic [cmbf_pkg::WEIGHT_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("tap word %0d %s got %0h want %0h",
                                      taps_seen, name, got, want));
        end
    endtask

    // Offer one word, hold it until accepted, queue its taps, maybe idle
    task automatic send_word(input cmbf_pkg::in_word_t word, input logic typed,
                             input logic [cmbf_pkg::WEIGHT_W-1:0] w0);
        tap_quad_t q;
        int        gap;
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge aclk); while (!s_ready);
        q = predict_taps(word, fs_reg);
        if (typed) begin
            q[0].weight = w0;
        end
        for (int k = 0; k < 4; k++) begin
            expected_taps.push_back(q[k]);
        end
        gap = (quiet_tail || long_stall_on || $urandom_range(0, 3) != 0) ?
              0 : $urandom_range(1, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Write the face size register once the block has drained
    task automatic load_face_size(input logic [cmbf_pkg::CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fs_reg = value;
    endtask

    // Stimulus: directed table, then random phases over several face sizes
    initial begin : stimulus
        cmbf_pkg::in_word_t word;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        fs_reg = cmbf_pkg::FS_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].fs != fs_reg) begin
                load_face_size(directed_rows[i].fs);
            end
            word.u    = directed_rows[i].u;
            word.v    = directed_rows[i].v;
            word.face = directed_rows[i].face;
            send_word(word, directed_rows[i].typed, directed_rows[i].w0);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            load_face_size((ph == 7) ? 13'($urandom_range(5, 4094)) : phase_sizes[ph]);
            quiet_tail = (ph == PHASE_COUNT - 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // stall the tap side for a long stretch while words keep coming
                if (ph == 2 && k == 0) begin
                    long_stall_req = 1'b1;
                end
                word.u    = pick_coord(effective_size(fs_reg));
                word.v    = pick_coord(effective_size(fs_reg));
                word.face = pick_face();
                send_word(word, 1'b0, '0);
            end
        end

        // Drain and give any stray tap time to show up
        s_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge aclk);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Tap side: random stalls, ready stretches, one long hold-off
    initial begin : tap_sink
        int hold;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                long_stall_on = 1'b1;
                m_ready <= 1'b0;
                for (hold = 0; hold < LONG_STALL_CYCLES; hold++) @(posedge aclk);
                long_stall_on = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // Compare each accepted tap with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_taps.size() == 0) begin
                report_mismatch($sformatf("tap word %0d arrived with nothing expected",
                                          taps_seen));
            end else begin
                tap_want = expected_taps.pop_front();
                check_field("tap", cmbf_pkg::WEIGHT_W'(m_data.tap),
                            cmbf_pkg::WEIGHT_W'(tap_want.tap));
                check_field("texel_x", cmbf_pkg::WEIGHT_W'(m_data.texel_x),
                            cmbf_pkg::WEIGHT_W'(tap_want.texel_x));
                check_field("texel_y", cmbf_pkg::WEIGHT_W'(m_data.texel_y),
                            cmbf_pkg::WEIGHT_W'(tap_want.texel_y));
                check_field("tap_face", cmbf_pkg::WEIGHT_W'(m_data.tap_face),
                            cmbf_pkg::WEIGHT_W'(tap_want.tap_face));
                check_field("weight", m_data.weight, tap_want.weight);
                check_field("last", cmbf_pkg::WEIGHT_W'(m_data.last),
                            cmbf_pkg::WEIGHT_W'(tap_want.last));
            end
            taps_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

/* filelist.f */
hdl/cmbf_pkg.sv
hdl/cmbf_neighbour.sv
hdl/cube_map_bilinear_footprint.sv
sim/cube_map_bilinear_footprint_tb.sv
